[rtl/core/tcgc_pkg.sv]
package tcgc_pkg;

  localparam int unsigned COL_W     = 9;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned Q12_W     = 13;
  localparam int unsigned VP_W      = 17;
  localparam int unsigned PW_W      = 26;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [VP_W-1:0]  ONE_Q16   = 17'h10000;
  localparam logic [Q12_W-1:0] Q12_ONE   = 13'd4096;
  localparam logic [Q12_W-1:0] POS_RESET = 13'd2048;
  // widths at or below this are a hard edge
  localparam logic [Q12_W-1:0] HARD_W    = 13'd4;
  localparam logic [Q12_W-1:0] HARD_P_LO = 13'd4;
  localparam logic [Q12_W-1:0] HARD_P_HI = 13'd4092;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_A,
    REG_COLOR_B,
    REG_WIDTH,
    REG_POSITION,
    REG_LAYOUT,
    REG_BLEND
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic [Q12_W-1:0]   width;
    logic [Q12_W-1:0]   position;
    logic               bar;
    logic               shift;
    logic [PW_W-1:0]    pw;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VP_W-1:0]  vp;
  } vp_item_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VP_W-1:0]  f;
  } fac_item_t;

endpackage

[rtl/core/tcgc_cfg.sv]
module tcgc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [tcgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcgc_pkg::COLOR_W-1:0]      cfg_data,
  output logic                              cfg_ready,
  output tcgc_pkg::cfg_t                    cfg
);

  logic [tcgc_pkg::COLOR_W-1:0] color_a_r;
  logic [tcgc_pkg::COLOR_W-1:0] color_b_r;
  logic [tcgc_pkg::Q12_W-1:0]   width_r;
  logic [tcgc_pkg::Q12_W-1:0]   position_r;
  logic                         bar_r;
  logic                         shift_r;
  logic [tcgc_pkg::PW_W-1:0]    pw_r;
  logic [tcgc_pkg::Q12_W-1:0]   q12_val;

  assign cfg_ready = 1'b1;

  // saturate Q1.12 values to 1.0
  assign q12_val = (cfg_data[tcgc_pkg::Q12_W-1:0] > tcgc_pkg::Q12_ONE) ?
                   tcgc_pkg::Q12_ONE : cfg_data[tcgc_pkg::Q12_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_a_r  <= '0;
      color_b_r  <= '0;
      width_r    <= '0;
      position_r <= tcgc_pkg::POS_RESET;
      bar_r      <= 1'b0;
      shift_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (tcgc_pkg::cfg_reg_t'(cfg_index))
        tcgc_pkg::REG_COLOR_A:  color_a_r  <= cfg_data;
        tcgc_pkg::REG_COLOR_B:  color_b_r  <= cfg_data;
        tcgc_pkg::REG_WIDTH:    width_r    <= q12_val;
        tcgc_pkg::REG_POSITION: position_r <= q12_val;
        tcgc_pkg::REG_LAYOUT:   bar_r      <= cfg_data[0];
        tcgc_pkg::REG_BLEND:    shift_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // width times position for the shift window, registered from the width and position registers
  always_ff @(posedge clk) begin
    pw_r <= tcgc_pkg::PW_W'(width_r) * tcgc_pkg::PW_W'(position_r);
  end

  always_comb begin
    cfg.color_a  = color_a_r;
    cfg.color_b  = color_b_r;
    cfg.width    = width_r;
    cfg.position = position_r;
    cfg.bar      = bar_r;
    cfg.shift    = shift_r;
    cfg.pw       = pw_r;
  end

endmodule

[rtl/core/tcgc_vpos.sv]
module tcgc_vpos #(
  parameter int COLUMNS = 320
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcgc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  logic [tcgc_pkg::COL_W-1:0]    in_column,
  output logic                          in_rdy,
  output logic                          out_valid,
  output tcgc_pkg::vp_item_t            out_item,
  input  logic                          out_rdy
);

  localparam int LAST = COLUMNS - 1;
  localparam int HALF = COLUMNS / 2;
  localparam int CW   = $clog2(COLUMNS);
  localparam int NW   = (CW > int'(tcgc_pkg::COL_W)) ? CW : int'(tcgc_pkg::COL_W);
  localparam int RSH  = 12;
  localparam int RW   = 16 + RSH + 1;
  localparam int PRW  = NW + RW;
  localparam int QW   = int'(tcgc_pkg::VP_W) + 1;
  localparam int QDW  = QW + CW;

  localparam logic [NW-1:0] LAST_N  = NW'(LAST);
  localparam logic [NW-1:0] HALF_N  = NW'(HALF);
  localparam logic [CW-1:0] DIV_BAR = CW'(LAST);
  localparam logic [CW-1:0] DIV_RND = CW'(HALF - 1);
  localparam logic [RW-1:0] RCP_BAR = RW'((64'd1 << (16 + RSH)) / 64'(LAST));
  localparam logic [RW-1:0] RCP_RND = RW'((64'd1 << (16 + RSH)) / 64'(HALF - 1));

  logic [3:0]                   v_r;
  logic [3:0]                   en;

  logic [tcgc_pkg::COL_W-1:0]   col0_r, col1_r, col2_r, col3_r;
  logic [NW-1:0]                n0_r, n1_r;
  logic [PRW-1:0]               prod1_r;
  logic [QW-1:0]                q2_r;
  logic [CW:0]                  rem2_r;
  logic [tcgc_pkg::VP_W-1:0]    vp3_r;

  logic [NW-1:0]                col_ext, col_sat, mirror, n_nxt;
  logic [CW-1:0]                div_sel;
  logic [RW-1:0]                rcp_sel;
  logic [PRW-1:0]               prod_nxt;
  logic [QW-1:0]                q_nxt;
  logic [QDW-1:0]               qd, nq;
  logic [CW:0]                  rem_nxt;
  logic [QW-1:0]                vp_raw;
  logic [tcgc_pkg::VP_W-1:0]    vp_nxt;

  assign en[3]  = !v_r[3] || out_rdy;
  assign en[2]  = !v_r[2] || en[3];
  assign en[1]  = !v_r[1] || en[2];
  assign en[0]  = !v_r[0] || en[1];
  assign in_rdy = en[0];

  assign div_sel = cfg.bar ? DIV_BAR : DIV_RND;
  assign rcp_sel = cfg.bar ? RCP_BAR : RCP_RND;

  // clamp the column to the strip, mirror it in round layout
  always_comb begin
    col_ext = NW'(in_column);
    col_sat = (col_ext > LAST_N) ? LAST_N : col_ext;
    mirror  = (col_sat < HALF_N) ? col_sat : LAST_N - col_sat;
    n_nxt   = cfg.bar ? col_sat : mirror;
  end

  // n * 2^16 / D as a reciprocal multiply, off by at most one below
  assign prod_nxt = PRW'(n0_r) * PRW'(rcp_sel);
  assign q_nxt    = prod1_r[RSH +: QW];

  always_comb begin
    qd      = QDW'(q_nxt) * QDW'(div_sel);
    nq      = QDW'({n1_r, 16'b0});
    rem_nxt = (CW+1)'(nq - qd);
  end

  always_comb begin
    vp_raw = (rem2_r >= {1'b0, div_sel}) ? q2_r + QW'(1) : q2_r;
    vp_nxt = (vp_raw > QW'(tcgc_pkg::ONE_Q16)) ? tcgc_pkg::ONE_Q16
                                                : vp_raw[tcgc_pkg::VP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      col0_r <= in_column;
      n0_r   <= n_nxt;
    end
    if (en[1] && v_r[0]) begin
      col1_r  <= col0_r;
      n1_r    <= n0_r;
      prod1_r <= prod_nxt;
    end
    if (en[2] && v_r[1]) begin
      col2_r <= col1_r;
      q2_r   <= q_nxt;
      rem2_r <= rem_nxt;
    end
    if (en[3] && v_r[2]) begin
      col3_r <= col2_r;
      vp3_r  <= vp_nxt;
    end
  end

  assign out_valid = v_r[3];

  always_comb begin
    out_item.col = col3_r;
    out_item.vp  = vp3_r;
  end

  a_rcp_error: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> ({1'b0, rem2_r} < {1'b0, div_sel, 1'b0}))
    else $error("reciprocal estimate off by more than one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rdy |=> out_valid && $stable(out_item))
    else $error("position output changed while held");

endmodule

[rtl/core/tcgc_fac.sv]
module tcgc_fac (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcgc_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  input  tcgc_pkg::vp_item_t   in_item,
  output logic                 in_rdy,
  output logic                 out_valid,
  output tcgc_pkg::fac_item_t  out_item,
  input  logic                 out_rdy
);

  localparam int QB   = 16;
  localparam int BPS  = 2;
  localparam int DST  = QB / BPS;
  localparam int NST  = DST + 1;
  localparam int DW   = int'(tcgc_pkg::VP_W);
  localparam int SW   = 36;

  typedef enum logic [1:0] {
    FAC_ZERO,
    FAC_ONE,
    FAC_DIV
  } fac_code_t;

  logic [NST-1:0]              v_r;
  logic [NST-1:0]              en;
  logic [tcgc_pkg::COL_W-1:0]  col_r  [NST];
  fac_code_t                   code_r [NST];
  logic [DW-1:0]               rem_r  [NST];
  logic [QB-1:0]               lo_r   [NST];
  logic [QB-1:0]               quo_r  [NST];
  logic [DW-1:0]               den_r  [NST];

  logic [DW-1:0]               rem_nxt [NST];
  logic [QB-1:0]               lo_nxt  [NST];
  logic [QB-1:0]               quo_nxt [NST];

  fac_code_t                   code_nxt;
  logic [2*QB-1:0]             num_nxt;
  logic [DW-1:0]               den_nxt;

  logic [tcgc_pkg::Q12_W-1:0]  w, p;
  logic [DW-1:0]               vp, p16, w8, s, e, span;
  logic [DW:0]                 pw_sum;
  logic signed [18:0]          sh_a;
  logic signed [SW-1:0]        num_s, lim_s;

  // window setup: hard edge, clamp or shift, down to a division or a fixed end
  always_comb begin
    w      = cfg.width;
    p      = cfg.position;
    vp     = in_item.vp;
    p16    = {p, 4'b0};
    w8     = {1'b0, w, 3'b0};
    pw_sum = {1'b0, p16} + {1'b0, w8};
    s      = (p16 > w8) ? p16 - w8 : '0;
    e      = (pw_sum > {1'b0, tcgc_pkg::ONE_Q16}) ? tcgc_pkg::ONE_Q16 : pw_sum[DW-1:0];
    span   = vp - s;
    sh_a   = $signed({2'b0, vp}) - $signed({1'b0, p, 5'b0}) + 19'sd32768;
    num_s  = $signed({sh_a[18], sh_a, 16'b0}) + $signed({2'b0, cfg.pw, 8'b0});
    lim_s  = $signed({3'b0, w, 20'b0});
    code_nxt = FAC_ZERO;
    num_nxt  = '0;
    den_nxt  = DW'(1);
    if (w <= tcgc_pkg::HARD_W) begin
      if (p <= tcgc_pkg::HARD_P_LO) begin
        code_nxt = FAC_ONE;
      end else if (p >= tcgc_pkg::HARD_P_HI) begin
        code_nxt = FAC_ZERO;
      end else begin
        code_nxt = (vp < p16) ? FAC_ZERO : FAC_ONE;
      end
    end else if (!cfg.shift) begin
      if (vp <= s) begin
        code_nxt = FAC_ZERO;
      end else if (vp >= e) begin
        code_nxt = FAC_ONE;
      end else begin
        code_nxt = FAC_DIV;
        num_nxt  = {span[QB-1:0], 16'b0};
        den_nxt  = e - s;
      end
    end else begin
      if (num_s <= 0) begin
        code_nxt = FAC_ZERO;
      end else if (num_s >= lim_s) begin
        code_nxt = FAC_ONE;
      end else begin
        code_nxt = FAC_DIV;
        num_nxt  = num_s[2*QB-1:0];
        den_nxt  = {w, 4'b0};
      end
    end
  end

  // restoring divide, two quotient bits per stage
  always_comb begin
    logic [DW-1:0] r;
    logic [QB-1:0] l;
    logic [QB-1:0] q;
    logic [DW:0]   t;
    rem_nxt[0] = '0;
    lo_nxt[0]  = '0;
    quo_nxt[0] = '0;
    for (int k = 1; k < NST; k++) begin
      r = rem_r[k-1];
      l = lo_r[k-1];
      q = quo_r[k-1];
      for (int b = 0; b < BPS; b++) begin
        t = {r, l[QB-1]};
        l = {l[QB-2:0], 1'b0};
        if (t >= {1'b0, den_r[k-1]}) begin
          r = DW'(t - {1'b0, den_r[k-1]});
          q = {q[QB-2:0], 1'b1};
        end else begin
          r = t[DW-1:0];
          q = {q[QB-2:0], 1'b0};
        end
      end
      rem_nxt[k] = r;
      lo_nxt[k]  = l;
      quo_nxt[k] = q;
    end
  end

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_rdy = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      col_r[0]  <= in_item.col;
      code_r[0] <= code_nxt;
      rem_r[0]  <= {1'b0, num_nxt[2*QB-1:QB]};
      lo_r[0]   <= num_nxt[QB-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= den_nxt;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k] && v_r[k-1]) begin
        col_r[k]  <= col_r[k-1];
        code_r[k] <= code_r[k-1];
        rem_r[k]  <= rem_nxt[k];
        lo_r[k]   <= lo_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NST-1];

  always_comb begin
    out_item.col = col_r[NST-1];
    case (code_r[NST-1])
      FAC_ZERO: out_item.f = '0;
      FAC_ONE:  out_item.f = tcgc_pkg::ONE_Q16;
      FAC_DIV:  out_item.f = {1'b0, quo_r[NST-1]};
      default:  out_item.f = '0;
    endcase
  end

  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && code_r[0] == FAC_DIV |-> rem_r[0] < den_r[0])
    else $error("dividend too large for a 16 bit quotient");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] && code_r[NST-1] == FAC_DIV |-> rem_r[NST-1] < den_r[NST-1])
    else $error("final remainder not below divisor");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rdy |=> out_valid && $stable(out_item))
    else $error("factor output changed while held");

endmodule

[rtl/core/tcgc_mix.sv]
module tcgc_mix (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcgc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  input  tcgc_pkg::fac_item_t           in_item,
  output logic                          in_rdy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcgc_pkg::COL_W-1:0]    out_column_out,
  output logic [tcgc_pkg::CH_W-1:0]     out_red,
  output logic [tcgc_pkg::CH_W-1:0]     out_green,
  output logic [tcgc_pkg::CH_W-1:0]     out_blue
);

  localparam int NCH = 3;
  localparam int PRW = 27;
  localparam int CHW = int'(tcgc_pkg::CH_W);

  logic [1:0]                  v_r;
  logic [1:0]                  en;
  logic [tcgc_pkg::COL_W-1:0]  colp_r, colo_r;
  logic [CHW-1:0]              a_r    [NCH];
  logic signed [PRW-1:0]       prod_r [NCH];
  logic [CHW-1:0]              ch_r   [NCH];

  logic [CHW-1:0]              a_nxt    [NCH];
  logic signed [PRW-1:0]       prod_nxt [NCH];
  logic [CHW-1:0]              ch_nxt   [NCH];

  assign en[1]  = !v_r[1] || !out_stall;
  assign en[0]  = !v_r[0] || en[1];
  assign in_rdy = en[0];

  // channel 0 is red, the highest byte
  always_comb begin
    logic [CHW-1:0]      b;
    logic signed [CHW:0] diff;
    for (int k = 0; k < NCH; k++) begin
      a_nxt[k]    = cfg.color_a[(NCH-1-k)*CHW +: CHW];
      b           = cfg.color_b[(NCH-1-k)*CHW +: CHW];
      diff        = $signed({1'b0, b}) - $signed({1'b0, a_nxt[k]});
      prod_nxt[k] = PRW'(diff) * PRW'($signed({1'b0, in_item.f}));
    end
  end

  always_comb begin
    logic signed [PRW-1:0] sum;
    for (int k = 0; k < NCH; k++) begin
      sum       = $signed({3'b0, a_r[k], 16'b0}) + prod_r[k];
      ch_nxt[k] = sum[16 +: CHW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      colp_r <= in_item.col;
      for (int k = 0; k < NCH; k++) begin
        a_r[k]    <= a_nxt[k];
        prod_r[k] <= prod_nxt[k];
      end
    end
    if (en[1] && v_r[0]) begin
      colo_r <= colp_r;
      for (int k = 0; k < NCH; k++) begin
        ch_r[k] <= ch_nxt[k];
      end
    end
  end

  assign out_valid      = v_r[1];
  assign out_column_out = colo_r;
  assign out_red        = ch_r[0];
  assign out_green      = ch_r[1];
  assign out_blue       = ch_r[2];

endmodule

[rtl/core/two_color_gradient_column.sv]
// channel   direction  handshake            payload
// in        in         in_valid/in_stall    in_column
// out       out        out_valid/out_stall  out_column_out, out_red, out_green, out_blue
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request per clock unless in_stall is high; 15 register stages: 4 position stages,
// 1 window setup, 8 divider stages of 2 quotient bits, 2 mix stages.
// The 16-step restoring divide of the blend factor sets the depth.
// Every stage advances on its own, so bubbles close up and in_stall rises only once
// all stages hold a request and out_stall is high.
// Reset clears all valid bits and loads the register defaults; cfg_ready is always high.
module two_color_gradient_column #(
  parameter int COLUMNS = 320
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tcgc_pkg::COL_W-1:0]        in_column,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcgc_pkg::COL_W-1:0]        out_column_out,
  output logic [tcgc_pkg::CH_W-1:0]         out_red,
  output logic [tcgc_pkg::CH_W-1:0]         out_green,
  output logic [tcgc_pkg::CH_W-1:0]         out_blue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcgc_pkg::COLOR_W-1:0]      cfg_data
);

  tcgc_pkg::cfg_t       cfg;
  logic                 vpos_rdy;
  logic                 vp_valid, vp_rdy;
  tcgc_pkg::vp_item_t   vp_item;
  logic                 fac_valid, fac_rdy;
  tcgc_pkg::fac_item_t  fac_item;

  assign in_stall = !vpos_rdy;

  tcgc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  tcgc_vpos #(
    .COLUMNS (COLUMNS)
  ) u_vpos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_column (in_column),
    .in_rdy    (vpos_rdy),
    .out_valid (vp_valid),
    .out_item  (vp_item),
    .out_rdy   (vp_rdy)
  );

  tcgc_fac u_fac (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (vp_valid),
    .in_item   (vp_item),
    .in_rdy    (vp_rdy),
    .out_valid (fac_valid),
    .out_item  (fac_item),
    .out_rdy   (fac_rdy)
  );

  tcgc_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (fac_valid),
    .in_item        (fac_item),
    .in_rdy         (fac_rdy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column_out (out_column_out),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue)
  );

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COLUMNS     = 320;
  localparam int     LATENCY     = 14;
  localparam int     RANDOM_REQS = 1400;
  localparam int     HOLD_AT     = 124;
  localparam int     HOLD_CYCLES = 300;
  localparam int     ERR_SHOWN   = 40;
  localparam longint UNIT        = 65536;
  localparam int     DATA_W      = tcgc_pkg::COLOR_W;
  localparam int     COL_BITS    = tcgc_pkg::COL_W;

  // indexes past the register list
  localparam logic [tcgc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [tcgc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [tcgc_pkg::COL_W-1:0] col;
    logic [tcgc_pkg::CH_W-1:0]  red;
    logic [tcgc_pkg::CH_W-1:0]  green;
    logic [tcgc_pkg::CH_W-1:0]  blue;
  } color_rec_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [tcgc_pkg::COL_W-1:0]     in_column = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [tcgc_pkg::COL_W-1:0]     out_column_out;
  logic [tcgc_pkg::CH_W-1:0]      out_red;
  logic [tcgc_pkg::CH_W-1:0]      out_green;
  logic [tcgc_pkg::CH_W-1:0]      out_blue;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tcgc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tcgc_pkg::COLOR_W-1:0]   cfg_data  = '0;

  // register copy, starting from the reset values
  logic [tcgc_pkg::COLOR_W-1:0] shade_a    = '0;
  logic [tcgc_pkg::COLOR_W-1:0] shade_b    = '0;
  logic [tcgc_pkg::Q12_W-1:0]   span_q12   = '0;
  logic [tcgc_pkg::Q12_W-1:0]   center_q12 = tcgc_pkg::POS_RESET;
  logic                         bar_layout = 1'b0;
  logic                         lift_blend = 1'b0;

  logic [tcgc_pkg::COL_W-1:0] column_q[$];
  color_rec_t                 color_q[$];
  color_rec_t                 next_color;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int tx_wait = 0;
  int stall_left = 0;
  int hold_left = 0;
  int n_sent = 0;
  int n_colors = 0;
  int n_blocked = 0;
  int n_errors = 0;
  int n_setups = 0;
  int n_writes = 0;
  int n_queued;

  two_color_gradient_column #(
    .COLUMNS(COLUMNS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_column(in_column),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_column_out(out_column_out),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unit_clamp(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  function automatic longint column_pos(logic [tcgc_pkg::COL_W-1:0] c);
    longint cl;
    longint m;
    cl = (longint'(c) > COLUMNS - 1) ? longint'(COLUMNS - 1) : longint'(c);
    if (bar_layout) return unit_clamp(cl * UNIT / (COLUMNS - 1));
    // mirror about the middle
    m = (cl < COLUMNS / 2) ? cl : COLUMNS - 1 - cl;
    return unit_clamp(m * UNIT / (COLUMNS / 2 - 1));
  endfunction

  function automatic longint blend_of(longint vp);
    longint w, p, s, e, lift, k, x, gs, ge;
    w = longint'(span_q12);
    p = longint'(center_q12);
    if (w <= 4) begin
      if (p <= 4) return UNIT;
      if (p >= 4092) return 0;
      return (vp < p * 16) ? 0 : UNIT;
    end
    if (!lift_blend) begin
      s = unit_clamp(p * 16 - w * 8);
      e = unit_clamp(p * 16 + w * 8);
      if (vp <= s) return 0;
      if (vp >= e) return UNIT;
      return (vp - s) * UNIT / (e - s);
    end
    // window slides with the position, all in Q.32
    lift = p * 32 - UNIT;
    k    = UNIT - w * 8;
    x    = vp * UNIT - lift * k;
    gs   = (32768 - w * 8) * UNIT;
    ge   = (32768 + w * 8) * UNIT;
    if (x <= gs) return 0;
    if (x >= ge) return UNIT;
    return unit_clamp((x - gs) / (w * 16));
  endfunction

  function automatic logic [tcgc_pkg::CH_W-1:0] mix(logic [tcgc_pkg::CH_W-1:0] a,
                                                    logic [tcgc_pkg::CH_W-1:0] b,
                                                    longint f);
    longint v;
    v = longint'(a) * UNIT + (longint'(b) - longint'(a)) * f;
    if (v < 0) v = 0;
    return v[23:16];
  endfunction

  function automatic color_rec_t paint_column(logic [tcgc_pkg::COL_W-1:0] c);
    color_rec_t r;
    longint f;
    f       = blend_of(column_pos(c));
    r.col   = c;
    r.red   = mix(shade_a[23:16], shade_b[23:16], f);
    r.green = mix(shade_a[15:8], shade_b[15:8], f);
    r.blue  = mix(shade_a[7:0], shade_b[7:0], f);
    return r;
  endfunction

  function automatic logic [tcgc_pkg::Q12_W-1:0] q12_sat(logic [tcgc_pkg::COLOR_W-1:0] d);
    logic [tcgc_pkg::Q12_W-1:0] q;
    q = d[tcgc_pkg::Q12_W-1:0];
    return (q > tcgc_pkg::Q12_ONE) ? tcgc_pkg::Q12_ONE : q;
  endfunction

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = int'($urandom_range(99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      if (n_errors <= ERR_SHOWN)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) n_blocked++;
      if (in_valid && !in_stall) begin
        color_q.push_back(paint_column(in_column));
        n_sent++;
      end
      // hold the request while stalled
      if (!in_valid || !in_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (column_q.size() > 0) begin
          in_column <= column_q.pop_front();
          in_valid  <= 1'b1;
          if (!tx_calm) tx_wait = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_colors++;
        if (color_q.size() == 0) begin
          n_errors++;
          if (n_errors <= ERR_SHOWN)
            $display("%0t: unexpected color for column %0d", $time, out_column_out);
        end else begin
          next_color = color_q.pop_front();
          check_field("column_out", 32'(next_color.col), 32'(out_column_out));
          check_field("red", 32'(next_color.red), 32'(out_red));
          check_field("green", 32'(next_color.green), 32'(out_green));
          check_field("blue", 32'(next_color.blue), 32'(out_blue));
        end
        // long hold-off so the pipe fills and backs up into the input
        if (n_colors == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left == 0 && !rx_calm) stall_left = gap_len();
      else if (stall_left > 0) stall_left--;
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (column_q.size() > 0 || in_valid || color_q.size() > 0);
  endtask

  // call at a rising edge; leaves cfg_valid high
  task automatic write_reg(logic [tcgc_pkg::CFG_IDX_W-1:0] idx,
                           logic [tcgc_pkg::COLOR_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk);
    while (!cfg_ready);
    n_writes++;
    case (idx)
      tcgc_pkg::REG_COLOR_A:  shade_a    = d;
      tcgc_pkg::REG_COLOR_B:  shade_b    = d;
      tcgc_pkg::REG_WIDTH:    span_q12   = q12_sat(d);
      tcgc_pkg::REG_POSITION: center_q12 = q12_sat(d);
      tcgc_pkg::REG_LAYOUT:   bar_layout = d[0];
      tcgc_pkg::REG_BLEND:    lift_blend = d[0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [tcgc_pkg::COLOR_W-1:0] a, logic [tcgc_pkg::COLOR_W-1:0] b,
                       logic [tcgc_pkg::COLOR_W-1:0] w, logic [tcgc_pkg::COLOR_W-1:0] p,
                       logic [tcgc_pkg::COLOR_W-1:0] lay,
                       logic [tcgc_pkg::COLOR_W-1:0] mode, bit spare);
    wait_drained();
    @(posedge clk);
    write_reg(tcgc_pkg::REG_COLOR_A, a);
    write_reg(tcgc_pkg::REG_COLOR_B, b);
    write_reg(tcgc_pkg::REG_WIDTH, w);
    write_reg(tcgc_pkg::REG_POSITION, p);
    write_reg(tcgc_pkg::REG_LAYOUT, lay);
    write_reg(tcgc_pkg::REG_BLEND, mode);
    if (spare) write_reg(($urandom_range(1) == 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                         DATA_W'($urandom()));
    cfg_valid <= 1'b0;
    n_setups++;
    @(negedge clk);
  endtask

  initial begin
    logic [tcgc_pkg::COLOR_W-1:0] a, b, w, p;
    int n, start;
    bit sweep;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // reset defaults: hard edge at the middle, round layout
    write_reg(tcgc_pkg::REG_COLOR_A, 24'h000000);
    write_reg(tcgc_pkg::REG_COLOR_B, 24'hFFFFFF);
    cfg_valid <= 1'b0;
    @(negedge clk);
    column_q.push_back(9'd0);
    column_q.push_back(9'd79);
    column_q.push_back(9'd80);
    column_q.push_back(9'd159);
    column_q.push_back(9'd160);
    column_q.push_back(9'd240);
    column_q.push_back(9'd319);
    column_q.push_back(9'd320);
    column_q.push_back(9'd511);

    // hard edge with the position at the low end
    setup(24'hFFFFFF, 24'h000000, 24'd4, 24'd4, 24'd1, 24'd0, 1'b0);
    column_q.push_back(9'd0);
    column_q.push_back(9'd319);

    // position written past 1.0 saturates to the high end
    setup(24'h123456, 24'hFEDCBA, 24'd0, 24'hFFFFFF, 24'd1, 24'd1, 1'b0);
    column_q.push_back(9'd0);
    column_q.push_back(9'd511);

    // full width clamp window, width written past 1.0
    setup(24'hFF0000, 24'h0000FF, 24'd5000, 24'd0, 24'd1, 24'd0, 1'b0);
    column_q.push_back(9'd0);
    column_q.push_back(9'd100);
    column_q.push_back(9'd319);

    // narrowest soft window in shift mode
    setup(24'h00FF00, 24'hFF00FF, 24'd5, 24'd2048, 24'd1, 24'd1, 1'b0);
    column_q.push_back(9'd159);
    column_q.push_back(9'd160);
    column_q.push_back(9'd161);

    setup(24'h80FF01, 24'h7F00FE, 24'd4096, 24'd4096, 24'd0, 24'd1, 1'b1);
    column_q.push_back(9'd0);
    column_q.push_back(9'd80);
    column_q.push_back(9'd159);

    setup(24'h0F0F0F, 24'hF0F0F0, 24'd2048, 24'd0, 24'd0, 24'd0, 1'b1);
    column_q.push_back(9'd0);
    column_q.push_back(9'd200);

    n_queued = 0;
    for (int ph = 0; n_queued < RANDOM_REQS; ph++) begin
      wait_drained();
      tx_calm = (ph == 0) || ($urandom_range(3) == 0);
      rx_calm = ($urandom_range(3) == 0);
      case ($urandom_range(5))
        0:       a = 24'h000000;
        1:       a = 24'hFFFFFF;
        default: a = DATA_W'($urandom());
      endcase
      case ($urandom_range(5))
        0:       b = 24'h000000;
        1:       b = 24'hFFFFFF;
        default: b = DATA_W'($urandom());
      endcase
      case ($urandom_range(7))
        0:       w = DATA_W'($urandom_range(4));
        1:       w = DATA_W'($urandom_range(5, 64));
        2:       w = 24'd4096;
        3:       w = DATA_W'($urandom());
        default: w = DATA_W'($urandom_range(4096));
      endcase
      case ($urandom_range(7))
        0:       p = DATA_W'($urandom_range(4));
        1:       p = DATA_W'($urandom_range(4092, 4096));
        2:       p = DATA_W'($urandom());
        default: p = DATA_W'($urandom_range(4096));
      endcase
      setup(a, b, w, p, DATA_W'($urandom()), DATA_W'($urandom()), $urandom_range(3) == 0);

      // first phase is long so the hold-off has requests to back up
      n     = (ph == 0) ? 300 : int'($urandom_range(30, 120));
      sweep = ($urandom_range(1) == 1);
      start = int'($urandom_range(COLUMNS - 1));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) column_q.push_back(COL_BITS'($urandom_range(511)));
        else if (sweep) column_q.push_back(COL_BITS'((start + i) % COLUMNS));
        else column_q.push_back(COL_BITS'($urandom_range(COLUMNS - 1)));
      end
      n_queued += n;
    end

    wait_drained();
    repeat (3 * LATENCY) @(negedge clk);
    $display("%0d columns over %0d register setups (%0d writes), %0d colors checked",
             n_sent, n_setups, n_writes, n_colors);
    $display("input backed up for %0d cycles during output hold-offs", n_blocked);
    if (n_errors == 0 && color_q.size() == 0) begin
      $display("two_color_gradient_column test passed");
    end else begin
      $display("%0d errors, %0d colors still expected", n_errors, color_q.size());
      $display("two_color_gradient_column test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d colors still expected", color_q.size());
    $display("two_color_gradient_column test failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/tcgc_pkg.sv
rtl/core/tcgc_cfg.sv
rtl/core/tcgc_vpos.sv
rtl/core/tcgc_fac.sv
rtl/core/tcgc_mix.sv
rtl/core/two_color_gradient_column.sv
dv/tb.sv
